[rtl/command_retransmit_tracker_assert.svh]
// ----------------------------------------------------------------------------
// command retransmit tracker assertion macros
// concurrent checks clocked on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef COMMAND_RETRANSMIT_TRACKER_ASSERT_SVH
`define COMMAND_RETRANSMIT_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define CRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define CRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CRT_ASSERT_NOW(lbl, ante, cons, msg)
`define CRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/crt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg
// shared widths, codes and record types of the command retransmit tracker
// ----------------------------------------------------------------------------
package crt_pkg;

  // table size limits
  localparam int DEPTH_CAP           = 8;
  localparam int TABLE_DEPTH_DEFAULT = 8;
  localparam int STAT_CNT_W          = 4;

  // field widths
  localparam int OP_W       = 2;
  localparam int CMD_W      = 16;
  localparam int DLY_W      = 16;
  localparam int TX_W       = 8;
  localparam int RES_W      = 8;
  localparam int ID_W       = 8;
  localparam int KIND_W     = 3;
  localparam int SLOT_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // ack result code meaning accepted
  localparam logic [RES_W-1:0] RESULT_ACCEPTED = 8'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_SYS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_COMP = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_SUBMIT = 2'd0,
    OP_ACK    = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TRANSMIT    = 3'd0,
    KIND_FULL        = 3'd1,
    KIND_ACKED       = 3'd2,
    KIND_NO_RESPONSE = 3'd3,
    KIND_NOT_FOR_US  = 3'd4,
    KIND_UNMATCHED   = 3'd5
  } kind_t;

  // one outstanding command as held in the table memory
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [TX_W-1:0]  sent;
    logic [TX_W-1:0]  wanted;
    logic [DLY_W-1:0] delay;
    logic [DLY_W-1:0] age;
  } entry_t;

  // one result transaction
  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [CMD_W-1:0]  command;
    logic [TX_W-1:0]   confirmation;
    logic [RES_W-1:0]  reported;
    logic              accepted;
    logic              last;
  } res_t;

  // walker status seen by the top level
  typedef struct packed {
    logic                  busy;
    logic [STAT_CNT_W-1:0] count;
  } stat_t;

  // depth actually served: one to eight entries
  function automatic int eff_depth(input int d);
    int r;
    r = d;
    if (r < 1) r = 1;
    if (r > DEPTH_CAP) r = DEPTH_CAP;
    return r;
  endfunction

endpackage

[rtl/crt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt channel interfaces
// valid/ready channels for commands in and results out
// ----------------------------------------------------------------------------
interface crt_in_if import crt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CMD_W-1:0]  cmd_num;
  logic [DLY_W-1:0]  resend_delay;
  logic [TX_W-1:0]   wanted_transmissions;
  logic [RES_W-1:0]  ack_result;
  logic [ID_W-1:0]   dest_sys;
  logic [ID_W-1:0]   dest_comp;

  modport source (
    output valid, op, cmd_num, resend_delay, wanted_transmissions,
           ack_result, dest_sys, dest_comp,
    input  ready
  );
  modport sink (
    input  valid, op, cmd_num, resend_delay, wanted_transmissions,
           ack_result, dest_sys, dest_comp,
    output ready
  );
endinterface

interface crt_out_if import crt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;
  logic [CMD_W-1:0]  result_command;
  logic [TX_W-1:0]   confirmation;
  logic [RES_W-1:0]  reported_result;
  logic              accepted;
  logic              last;

  modport source (
    output valid, kind, slot, result_command, confirmation, reported_result,
           accepted, last,
    input  ready
  );
  modport sink (
    input  valid, kind, slot, result_command, confirmation, reported_result,
           accepted, last,
    output ready
  );
endinterface

[rtl/crt_table_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_table_mem
// command table storage: one write port, one registered read port
// ----------------------------------------------------------------------------
module crt_table_mem import crt_pkg::*; #(
  parameter int DEPTH = DEPTH_CAP,
  parameter int IDX_W = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem_r [DEPTH];
  entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, registered, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/crt_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_out_reg
// output register between the walker and the result channel
// ----------------------------------------------------------------------------
module crt_out_reg import crt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  res_t             push_data,
  output logic             space,
  crt_out_if.source        out_ch
);

  logic full_r;
  res_t data_r;

  // room when empty or when the held transaction leaves this cycle
  assign space = !full_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (push) begin
      full_r <= 1'b1;
    end else if (out_ch.ready) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

  assign out_ch.valid           = full_r;
  assign out_ch.kind            = data_r.kind;
  assign out_ch.slot            = data_r.slot;
  assign out_ch.result_command  = data_r.command;
  assign out_ch.confirmation    = data_r.confirmation;
  assign out_ch.reported_result = data_r.reported;
  assign out_ch.accepted        = data_r.accepted;
  assign out_ch.last            = data_r.last;

endmodule

[rtl/crt_walker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_walker
// command sequencer: appends, walks the table for acks and ticks, closes gaps
// ----------------------------------------------------------------------------
module crt_walker import crt_pkg::*; #(
  parameter int DEPTH = DEPTH_CAP,
  parameter int IDX_W = 3,
  parameter int CNT_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  crt_in_if.sink           in_ch,
  input  logic [ID_W-1:0]  own_sys,
  input  logic [ID_W-1:0]  own_comp,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output entry_t           mem_wdata,
  output logic             mem_re,
  output logic [IDX_W-1:0] mem_raddr,
  input  entry_t           mem_rdata,
  output logic             push,
  output res_t             push_data,
  input  logic             space,
  output stat_t            stat
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_PROC  = 4'b0100,
    ST_FLUSH = 4'b1000
  } wk_state_t;

  wk_state_t        state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [RES_W-1:0] ack_res_r, ack_res_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] wr_r, wr_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             found_r, found_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  res_t             pend_r, pend_nxt;

  // per-entry evaluation of the word just read
  logic [DLY_W-1:0] age_inc;
  logic             timeout;
  logic             can_send;
  logic             cmd_hit;
  logic             last_entry;
  logic [CNT_W-1:0] shift_addr;
  entry_t           upd_entry;
  res_t             new_res;

  always_comb begin
    age_inc    = (mem_rdata.age == '1) ? mem_rdata.age : mem_rdata.age + DLY_W'(1);
    timeout    = age_inc > mem_rdata.delay;
    can_send   = mem_rdata.sent < mem_rdata.wanted;
    cmd_hit    = mem_rdata.command == cmd_r;
    last_entry = (idx_r + CNT_W'(1)) == n_r;
    shift_addr = idx_r - CNT_W'(1);

    // aged entry, resent if due and allowed
    upd_entry = mem_rdata;
    upd_entry.age = age_inc;
    if (timeout && can_send) begin
      upd_entry.sent = mem_rdata.sent + TX_W'(1);
      upd_entry.age  = '0;
    end

    // result of a timeout
    new_res              = '0;
    new_res.slot         = SLOT_W'(idx_r);
    new_res.command      = mem_rdata.command;
    new_res.kind         = can_send ? KIND_TRANSMIT : KIND_NO_RESPONSE;
    new_res.confirmation = upd_entry.sent;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cmd_nxt        = cmd_r;
    ack_res_nxt    = ack_res_r;
    idx_nxt        = idx_r;
    wr_nxt         = wr_r;
    n_nxt          = n_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    mem_we         = 1'b0;
    mem_waddr      = wr_r[IDX_W-1:0];
    mem_wdata      = upd_entry;
    mem_re         = 1'b0;
    mem_raddr      = idx_r[IDX_W-1:0];
    push           = 1'b0;
    push_data      = pend_r;
    in_ch.ready    = state_r == ST_IDLE;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt         = op_t'(in_ch.op);
          cmd_nxt        = in_ch.cmd_num;
          ack_res_nxt    = in_ch.ack_result;
          idx_nxt        = '0;
          wr_nxt         = '0;
          n_nxt          = count_r;
          found_nxt      = 1'b0;
          pend_valid_nxt = 1'b0;
          pend_nxt       = '0;
          pend_nxt.command = in_ch.cmd_num;
          unique case (op_t'(in_ch.op))
            OP_SUBMIT: begin
              pend_valid_nxt = 1'b1;
              state_nxt      = ST_FLUSH;
              if (count_r == CNT_W'(DEPTH)) begin
                pend_nxt.kind = KIND_FULL;
              end else begin
                // append at the tail, sent once
                mem_we            = 1'b1;
                mem_waddr         = count_r[IDX_W-1:0];
                mem_wdata.command = in_ch.cmd_num;
                mem_wdata.sent    = TX_W'(1);
                mem_wdata.wanted  = in_ch.wanted_transmissions;
                mem_wdata.delay   = in_ch.resend_delay;
                mem_wdata.age     = '0;
                count_nxt         = count_r + CNT_W'(1);
                pend_nxt.kind         = KIND_TRANSMIT;
                pend_nxt.slot         = SLOT_W'(count_r);
                pend_nxt.confirmation = TX_W'(1);
              end
            end
            OP_ACK: begin
              if (in_ch.dest_sys != own_sys || in_ch.dest_comp != own_comp) begin
                pend_nxt.kind  = KIND_NOT_FOR_US;
                pend_valid_nxt = 1'b1;
                state_nxt      = ST_FLUSH;
              end else if (count_r == '0) begin
                pend_nxt.kind  = KIND_UNMATCHED;
                pend_valid_nxt = 1'b1;
                state_nxt      = ST_FLUSH;
              end else begin
                state_nxt = ST_READ;
              end
            end
            OP_TICK: begin
              if (count_r != '0) begin
                state_nxt = ST_READ;
              end
            end
            OP_NONE: begin
              state_nxt = ST_IDLE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_READ: begin
        mem_re    = 1'b1;
        state_nxt = ST_PROC;
      end

      ST_PROC: begin
        if (op_r == OP_ACK) begin
          // search for the oldest match, then shift the rest down by one
          if (!found_r) begin
            if (cmd_hit) begin
              found_nxt             = 1'b1;
              count_nxt             = count_r - CNT_W'(1);
              pend_valid_nxt        = 1'b1;
              pend_nxt              = '0;
              pend_nxt.kind         = KIND_ACKED;
              pend_nxt.slot         = SLOT_W'(idx_r);
              pend_nxt.command      = cmd_r;
              pend_nxt.confirmation = mem_rdata.sent;
              pend_nxt.reported     = ack_res_r;
              pend_nxt.accepted     = ack_res_r == RESULT_ACCEPTED;
            end
          end else begin
            mem_we    = 1'b1;
            mem_waddr = shift_addr[IDX_W-1:0];
            mem_wdata = mem_rdata;
          end
          if (last_entry) begin
            state_nxt = ST_FLUSH;
            if (!found_r && !cmd_hit) begin
              pend_valid_nxt = 1'b1;
              pend_nxt       = '0;
              pend_nxt.kind  = KIND_UNMATCHED;
              pend_nxt.command = cmd_r;
            end
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_READ;
          end
        end else begin
          // tick: age, resend or drop, keep survivors packed at the front
          if (!(timeout && pend_valid_r) || space) begin
            if (timeout && pend_valid_r) begin
              push           = 1'b1;
              push_data      = pend_r;
              push_data.last = 1'b0;
            end
            if (timeout) begin
              pend_valid_nxt = 1'b1;
              pend_nxt       = new_res;
            end
            if (!timeout || can_send) begin
              mem_we = 1'b1;
              wr_nxt = wr_r + CNT_W'(1);
            end
            if (last_entry) begin
              count_nxt = wr_nxt;
              state_nxt = ST_FLUSH;
            end else begin
              idx_nxt   = idx_r + CNT_W'(1);
              state_nxt = ST_READ;
            end
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (space) begin
          push           = 1'b1;
          push_data      = pend_r;
          push_data.last = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      found_r      <= found_nxt;
    end
  end

  // working registers of the current transaction
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    cmd_r     <= cmd_nxt;
    ack_res_r <= ack_res_nxt;
    idx_r     <= idx_nxt;
    wr_r      <= wr_nxt;
    n_r       <= n_nxt;
    pend_r    <= pend_nxt;
  end

  assign stat.busy  = state_r != ST_IDLE;
  assign stat.count = STAT_CNT_W'(count_r);

endmodule

[rtl/command_retransmit_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_retransmit_tracker
// arrival-ordered table of outstanding commands with ack matching and timeouts
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  in_ch    sink       submit, ack or tick transaction
//  out_ch   source     transmit / full / acked / no response / ignored / unmatched results
//  cfg_*    write      own system id (index 0), own component id (index 1)
//
// submit, foreign ack, ack on an empty table: a flush state pushes the result into the output register
// own ack and tick on a filled table: a read state and a process state per occupied
// entry, then a flush state, paced by the single registered table read port
// tick on an empty table and unknown op: the walker stays idle, no result
// reset leaves the table empty at once; no clearing pass
// a stalled result channel holds the walk until the output register frees
// ----------------------------------------------------------------------------
`include "command_retransmit_tracker_assert.svh"

module command_retransmit_tracker import crt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  crt_in_if.sink                in_ch,
  crt_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH_EFF = eff_depth(TABLE_DEPTH);
  localparam int IDX_W     = (DEPTH_EFF > 1) ? $clog2(DEPTH_EFF) : 1;
  localparam int CNT_W     = $clog2(DEPTH_EFF + 1);

  logic [ID_W-1:0] own_sys_r;
  logic [ID_W-1:0] own_comp_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;
  logic             push;
  res_t             push_data;
  logic             space;
  stat_t            stat;

  // node identity registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_sys_r  <= '0;
      own_comp_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_SYS:  own_sys_r  <= cfg_wdata[ID_W-1:0];
        REG_OWN_COMP: own_comp_r <= cfg_wdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  crt_walker #(
    .DEPTH (DEPTH_EFF),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .own_sys   (own_sys_r),
    .own_comp  (own_comp_r),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .stat      (stat)
  );

  crt_table_mem #(
    .DEPTH (DEPTH_EFF),
    .IDX_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  crt_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .out_ch    (out_ch)
  );

  // checks
  `CRT_ASSERT_NOW(a_count_bound, 1'b1, stat.count <= STAT_CNT_W'(DEPTH_EFF), "table count overflow")
  `CRT_ASSERT_NOW(a_push_has_room, push, space, "result pushed into a full output register")
  `CRT_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready && (in_ch.op == OP_SUBMIT || in_ch.op == OP_ACK), stat.busy && !in_ch.ready, "walker idle after submit or ack")

endmodule
